// File: src/apfd_pkg.sv
// Package for the apogee flight phase detector.
// Holds phase codes, register indexes, reset values and fixed field widths.
// No dependencies.
`default_nettype none

package apfd_pkg;

  // Default widths of altitude samples and of the sample counters
  localparam int ALT_WIDTH_DEF   = 24;
  localparam int COUNT_WIDTH_DEF = 8;

  // Fixed widths of the sample-count registers and of the register index
  localparam int SAMPLES_WIDTH   = 8;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int PHASE_WIDTH     = 3;

  // Flight phase codes
  typedef enum logic [PHASE_WIDTH-1:0] {
    PH_PAD     = 3'd0,
    PH_ASCENT  = 3'd1,
    PH_APOGEE  = 3'd2,
    PH_RELEASE = 3'd3,
    PH_LANDED  = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAKEOFF_HEIGHT  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAKEOFF_SAMPLES = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DESCENT_DROP    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DESCENT_SAMPLES = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_APOGEE      = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LANDING_HEIGHT  = 3'd5;

  // Register reset values
  localparam int RST_TAKEOFF_HEIGHT  = 200;
  localparam int RST_TAKEOFF_SAMPLES = 3;
  localparam int RST_DESCENT_DROP    = 100;
  localparam int RST_DESCENT_SAMPLES = 2;
  localparam int RST_MIN_APOGEE      = 400;
  localparam int RST_LANDING_HEIGHT  = 1000;

endpackage

`default_nettype wire

// File: src/apfd_if.sv
// Valid/ready channel interfaces of the apogee flight phase detector.
// Depends on apfd_pkg for the phase field width and the default altitude width.
`default_nettype none

// Altitude sample channel
interface apfd_in_if #(
  parameter int ALT_WIDTH = apfd_pkg::ALT_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ALT_WIDTH-1:0] altitude_cm;

  modport source (output valid, output altitude_cm, input ready);
  modport sink   (input valid, input altitude_cm, output ready);
endinterface

// Phase result channel
interface apfd_out_if #(
  parameter int ALT_WIDTH = apfd_pkg::ALT_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [apfd_pkg::PHASE_WIDTH-1:0]     phase;
  logic                                 deploy;
  logic                                 landed_flag;
  logic signed [ALT_WIDTH-1:0]          peak_altitude_cm;

  modport source (output valid, output phase, output deploy, output landed_flag,
                  output peak_altitude_cm, input ready);
  modport sink   (input valid, input phase, input deploy, input landed_flag,
                  input peak_altitude_cm, output ready);
endinterface

`default_nettype wire

// File: src/apogee_flight_phase_detector_unit.sv
// Apogee flight phase detector: peak tracking and pad/ascent/apogee/release/landed
// sequencing of an altitude sample stream. Depends on apfd_pkg and apfd_if.
//
// Pipeline: an accepted sample passes the input register, then the state update and
// result register, to its result on out_ch. Throughput: one sample per cycle while
// out_ch is not stalling; the phase state and peak update between the two registers.
// Reset (rst, synchronous): phase pad, peak 0, counters and flags cleared,
// configuration registers back to their defaults, both pipeline stages empty.
`default_nettype none

module apogee_flight_phase_detector_unit #(
  parameter int ALT_WIDTH   = apfd_pkg::ALT_WIDTH_DEF,
  parameter int COUNT_WIDTH = apfd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [apfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ALT_WIDTH-2:0]                 cfg_data,
  apfd_in_if.sink                                   in_ch,
  apfd_out_if.source                                out_ch
);

  import apfd_pkg::*;

  localparam int THR_WIDTH = ALT_WIDTH - 1;
  localparam int CMP_WIDTH = (COUNT_WIDTH > SAMPLES_WIDTH) ? COUNT_WIDTH : SAMPLES_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers
  logic [THR_WIDTH-1:0]     takeoff_height;
  logic [SAMPLES_WIDTH-1:0] takeoff_samples;
  logic [THR_WIDTH-1:0]     descent_drop;
  logic [SAMPLES_WIDTH-1:0] descent_samples;
  logic [THR_WIDTH-1:0]     min_apogee;
  logic [THR_WIDTH-1:0]     landing_height;

  // Flight state
  phase_t                      phase_reg;
  logic signed [ALT_WIDTH-1:0] peak_reg;
  logic [COUNT_WIDTH-1:0]      launch_count;
  logic [COUNT_WIDTH-1:0]      descent_count;
  logic                        deploy_reg;
  logic                        landed_reg;

  // Input stage
  logic                        in_valid_q;
  logic signed [ALT_WIDTH-1:0] alt_q;

  // Output stage
  logic out_valid;
  logic advance;
  logic fire;

  // Next-state values
  phase_t                      phase_next;
  logic signed [ALT_WIDTH-1:0] peak_next;
  logic [COUNT_WIDTH-1:0]      launch_count_next;
  logic [COUNT_WIDTH-1:0]      descent_count_next;
  logic                        deploy_next;
  logic                        landed_next;

  // Datapath compares
  logic signed [ALT_WIDTH-1:0] peak_max;
  logic signed [ALT_WIDTH:0]   drop_diff;
  logic                        above_takeoff;
  logic                        descending;
  logic                        above_min_apogee;
  logic                        below_landing;
  logic [COUNT_WIDTH-1:0]      launch_bump;
  logic [COUNT_WIDTH-1:0]      descent_bump;

  // Handshake: the compute stage fires when the result register is free
  assign advance     = !out_valid || out_ch.ready;
  assign fire        = in_valid_q && advance;
  assign in_ch.ready = !in_valid_q || advance;
  assign out_ch.valid = out_valid;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      takeoff_height  <= THR_WIDTH'(RST_TAKEOFF_HEIGHT);
      takeoff_samples <= SAMPLES_WIDTH'(RST_TAKEOFF_SAMPLES);
      descent_drop    <= THR_WIDTH'(RST_DESCENT_DROP);
      descent_samples <= SAMPLES_WIDTH'(RST_DESCENT_SAMPLES);
      min_apogee      <= THR_WIDTH'(RST_MIN_APOGEE);
      landing_height  <= THR_WIDTH'(RST_LANDING_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAKEOFF_HEIGHT:  takeoff_height  <= cfg_data;
        REG_TAKEOFF_SAMPLES: takeoff_samples <= cfg_data[SAMPLES_WIDTH-1:0];
        REG_DESCENT_DROP:    descent_drop    <= cfg_data;
        REG_DESCENT_SAMPLES: descent_samples <= cfg_data[SAMPLES_WIDTH-1:0];
        REG_MIN_APOGEE:      min_apogee      <= cfg_data;
        REG_LANDING_HEIGHT:  landing_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare the sample against peak and thresholds
  always_comb begin
    peak_max         = (alt_q > peak_reg) ? alt_q : peak_reg;
    drop_diff        = {peak_max[ALT_WIDTH-1], peak_max} - {alt_q[ALT_WIDTH-1], alt_q};
    above_takeoff    = alt_q > $signed({1'b0, takeoff_height});
    descending       = drop_diff >= $signed({2'b00, descent_drop});
    above_min_apogee = peak_max > $signed({1'b0, min_apogee});
    below_landing    = alt_q < $signed({1'b0, landing_height});
    launch_bump      = (launch_count == CNT_MAX) ? CNT_MAX : launch_count + 1'b1;
    descent_bump     = (descent_count == CNT_MAX) ? CNT_MAX : descent_count + 1'b1;
  end

  // Phase sequencing for one sample
  always_comb begin
    phase_next         = phase_reg;
    peak_next          = peak_max;
    launch_count_next  = launch_count;
    descent_count_next = descent_count;
    deploy_next        = deploy_reg;
    landed_next        = landed_reg;
    case (phase_reg)
      PH_PAD: begin
        launch_count_next = above_takeoff ? launch_bump : '0;
        if (CMP_WIDTH'(launch_count_next) >= CMP_WIDTH'(takeoff_samples)) begin
          peak_next  = alt_q;
          phase_next = PH_ASCENT;
        end
      end
      PH_ASCENT: begin
        descent_count_next = descending ? descent_bump : '0;
        if ((CMP_WIDTH'(descent_count_next) >= CMP_WIDTH'(descent_samples)) &&
            above_min_apogee) begin
          phase_next = PH_APOGEE;
        end
      end
      PH_APOGEE: begin
        deploy_next = 1'b1;
        phase_next  = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (below_landing) begin
          phase_next = PH_LANDED;
        end
      end
      PH_LANDED: begin
        landed_next = 1'b1;
      end
      default: begin
        phase_next = PH_PAD;
      end
    endcase
  end

  // Hold the flight state, advance on each fired sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_PAD;
      peak_reg      <= '0;
      launch_count  <= '0;
      descent_count <= '0;
      deploy_reg    <= 1'b0;
      landed_reg    <= 1'b0;
    end else if (fire) begin
      phase_reg     <= phase_next;
      peak_reg      <= peak_next;
      launch_count  <= launch_count_next;
      descent_count <= descent_count_next;
      deploy_reg    <= deploy_next;
      landed_reg    <= landed_next;
    end
  end

  // Input register: take a sample whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      alt_q <= in_ch.altitude_cm;
    end
  end

  // Result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.phase            <= phase_next;
      out_ch.deploy           <= deploy_next;
      out_ch.landed_flag      <= landed_next;
      out_ch.peak_altitude_cm <= peak_next;
    end
  end

  // Deploy is sticky
  a_deploy_sticky: assert property (@(posedge clk) disable iff (rst)
    deploy_reg |=> deploy_reg)
    else $error("deploy dropped after being set");

  // Landed flag only ever seen in landed phase
  a_landed_phase: assert property (@(posedge clk) disable iff (rst)
    landed_reg |-> (phase_reg == PH_LANDED))
    else $error("landed flag set outside landed phase");

  // Release and landed are only reached through the deploy step
  a_deploy_before_release: assert property (@(posedge clk) disable iff (rst)
    ((phase_reg == PH_RELEASE) || (phase_reg == PH_LANDED)) |-> deploy_reg)
    else $error("release or landed without deploy");

  // A fired sample always leaves a result behind
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("fired sample produced no result");

endmodule

`default_nettype wire

// File: tb/apfd_flight_checker.sv
// Scoreboard for the apogee flight phase detector: mirrors register writes,
// predicts one flight result per accepted altitude sample and compares it.
// Depends on apfd_pkg and the apfd_in_if / apfd_out_if channel interfaces.

module apfd_flight_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [apfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [apfd_pkg::ALT_WIDTH_DEF-2:0]   cfg_data,
  apfd_in_if                                        in_ch,
  apfd_out_if                                       out_ch,
  output int                                        fails,
  output int                                        pending
);

  import apfd_pkg::*;

  localparam int AW = ALT_WIDTH_DEF;
  localparam int CW = COUNT_WIDTH_DEF;

  typedef struct {
    phase_t                 phase;
    logic                   deploy;
    logic                   landed;
    logic signed [AW-1:0]   peak;
  } flight_result_t;

  flight_result_t expected_q[$];

  // Register copies
  logic [AW-2:0]            takeoff_height;
  logic [SAMPLES_WIDTH-1:0] takeoff_count;
  logic [AW-2:0]            descent_drop;
  logic [SAMPLES_WIDTH-1:0] descent_count;
  logic [AW-2:0]            min_apogee;
  logic [AW-2:0]            landing_height;

  // Flight state copies
  phase_t                   flight_phase;
  logic signed [AW-1:0]     peak_alt;
  logic [CW-1:0]            launch_run;
  logic [CW-1:0]            descent_run;
  logic                     deploy_latched;
  logic                     landed_latched;

  // Advance the flight state by one sample and return what the block must show
  function automatic flight_result_t advance_flight(input logic signed [AW-1:0] alt);
    flight_result_t r;
    longint         a;
    a = longint'(alt);
    if (alt > peak_alt) peak_alt = alt;
    case (flight_phase)
      PH_PAD: begin
        if (a > longint'(takeoff_height)) begin
          if (launch_run != '1) launch_run = launch_run + 1'b1;
        end else begin
          launch_run = '0;
        end
        if (launch_run >= takeoff_count) begin
          peak_alt     = alt;
          flight_phase = PH_ASCENT;
        end
      end
      PH_ASCENT: begin
        if (longint'(peak_alt) - a >= longint'(descent_drop)) begin
          if (descent_run != '1) descent_run = descent_run + 1'b1;
        end else begin
          descent_run = '0;
        end
        if (descent_run >= descent_count && longint'(peak_alt) > longint'(min_apogee))
          flight_phase = PH_APOGEE;
      end
      PH_APOGEE: begin
        deploy_latched = 1'b1;
        flight_phase   = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (a < longint'(landing_height)) flight_phase = PH_LANDED;
      end
      PH_LANDED: begin
        landed_latched = 1'b1;
      end
      default: begin
        flight_phase = PH_PAD;
      end
    endcase
    r.phase  = flight_phase;
    r.deploy = deploy_latched;
    r.landed = landed_latched;
    r.peak   = peak_alt;
    return r;
  endfunction

  always @(posedge clk) begin
    flight_result_t want;
    int             errs;
    errs = 0;
    if (rst) begin
      takeoff_height = (AW-1)'(RST_TAKEOFF_HEIGHT);
      takeoff_count  = SAMPLES_WIDTH'(RST_TAKEOFF_SAMPLES);
      descent_drop   = (AW-1)'(RST_DESCENT_DROP);
      descent_count  = SAMPLES_WIDTH'(RST_DESCENT_SAMPLES);
      min_apogee     = (AW-1)'(RST_MIN_APOGEE);
      landing_height = (AW-1)'(RST_LANDING_HEIGHT);
      flight_phase   = PH_PAD;
      peak_alt       = '0;
      launch_run     = '0;
      descent_run    = '0;
      deploy_latched = 1'b0;
      landed_latched = 1'b0;
      expected_q.delete();
      fails <= 0;
    end else begin
      // Compare the result transaction against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, phase %0d peak %0d", $time,
                   out_ch.phase, out_ch.peak_altitude_cm);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.phase !== want.phase) begin
            $display("%0t: phase expected %0d, got %0d", $time, want.phase, out_ch.phase);
            errs++;
          end
          if (out_ch.deploy !== want.deploy) begin
            $display("%0t: deploy expected %0b, got %0b", $time, want.deploy, out_ch.deploy);
            errs++;
          end
          if (out_ch.landed_flag !== want.landed) begin
            $display("%0t: landed_flag expected %0b, got %0b", $time, want.landed,
                     out_ch.landed_flag);
            errs++;
          end
          if (out_ch.peak_altitude_cm !== want.peak) begin
            $display("%0t: peak_altitude_cm expected %0d, got %0d", $time, want.peak,
                     out_ch.peak_altitude_cm);
            errs++;
          end
        end
      end

      // Mirror register writes; indexes past the list are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_TAKEOFF_HEIGHT:  takeoff_height = cfg_data;
          REG_TAKEOFF_SAMPLES: takeoff_count  = cfg_data[SAMPLES_WIDTH-1:0];
          REG_DESCENT_DROP:    descent_drop   = cfg_data;
          REG_DESCENT_SAMPLES: descent_count  = cfg_data[SAMPLES_WIDTH-1:0];
          REG_MIN_APOGEE:      min_apogee     = cfg_data;
          REG_LANDING_HEIGHT:  landing_height = cfg_data;
          default: ;
        endcase
      end

      // Predict for each accepted sample transaction
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(advance_flight(in_ch.altitude_cm));

      if (errs != 0) fails <= fails + errs;
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/tb_apogee_flight_phase_detector_unit.sv
// Top of the apogee flight phase detector testbench: clock, reset, sample and
// register stimulus, output stalls and the verdict.
// Depends on apfd_pkg, apfd_if, the block itself and apfd_flight_checker.

module tb_apogee_flight_phase_detector_unit;
  import apfd_pkg::*;

  localparam int AW          = ALT_WIDTH_DEF;
  localparam int ALT_MAX     = 8388607;
  localparam int ALT_MIN     = -8388608;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  // Pad samples under default thresholds: extremes and launch runs that break early
  localparam int PAD_SEQ[11] = '{ALT_MAX, ALT_MIN, 0, -1, 200, 201, 201, 200, 201, 201, 1};
  // Descending runs: one broken by a return to the peak, then one that confirms apogee
  localparam int APOGEE_SEQ[8] = '{ALT_MAX, ALT_MIN, ALT_MIN, ALT_MAX,
                                   ALT_MIN, ALT_MIN, ALT_MIN, 12345};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_TAKEOFF_HEIGHT;
  logic [AW-2:0]              cfg_data = '0;
  int                         fail_count;
  int                         pending_results;
  int                         hold_asks = 0;
  int                         hold_taken = 0;
  int                         hold_left = 0;
  logic [31:0]                sink_cycle = '0;
  int                         cycle_count = 0;
  int                         burst_left = 0;
  int                         samples_sent = 0;
  int                         reg_writes = 0;

  apfd_in_if  #(.ALT_WIDTH(AW)) in_ch ();
  apfd_out_if #(.ALT_WIDTH(AW)) out_ch ();

  apogee_flight_phase_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  apfd_flight_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fails     (fail_count),
    .pending   (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: long hold-off on request, else a slowly rotating stall pattern
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_taken != hold_asks) begin
      hold_taken   <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (sink_cycle[9:8])
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (sink_cycle[2:0] < 3'd5);
      endcase
    end
  end

  function automatic logic signed [AW-1:0] alt_between(input longint lo, input longint hi);
    return AW'(lo + longint'($urandom_range(0, hi - lo)));
  endfunction

  // Offer one sample and hold it until accepted; drop valid only between bursts
  task automatic push_alt(input logic signed [AW-1:0] alt);
    in_ch.valid       <= 1'b1;
    in_ch.altitude_cm <= alt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[AW-2:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Pad samples around a takeoff height; every run above it breaks before launch
  task automatic pad_run(input int height, input int need, input int count);
    int                   run;
    logic signed [AW-1:0] a;
    settle();
    write_reg(REG_TAKEOFF_HEIGHT, height);
    write_reg(REG_TAKEOFF_SAMPLES, need);
    run = need;
    repeat (count) begin
      if (height == ALT_MAX) begin
        a = AW'($urandom);
      end else if (run >= need - 1 || $urandom_range(0, 9) < 3) begin
        a   = ($urandom_range(0, 3) == 0) ? AW'(height) : alt_between(ALT_MIN, height);
        run = 0;
      end else begin
        a   = ($urandom_range(0, 3) == 0) ? AW'(height + 1) : alt_between(height + 1, ALT_MAX);
        run++;
      end
      push_alt(a);
    end
  endtask

  // Ascent samples as climbs and falls with random content, plus noise
  task automatic climb_run(input int drop, input int need, input int count);
    longint cur;
    longint fall;
    int     k;
    settle();
    write_reg(REG_DESCENT_DROP, drop);
    write_reg(REG_DESCENT_SAMPLES, need);
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 4) == 0) begin
        push_alt(AW'($urandom));
        k++;
      end else begin
        cur = alt_between(ALT_MIN / 2, ALT_MAX / 2);
        repeat ($urandom_range(1, 6)) begin
          cur = cur + longint'($urandom_range(0, 65535));
          push_alt(AW'(cur));
          k++;
        end
        repeat ($urandom_range(1, (need < 10) ? need + 2 : 12)) begin
          fall = cur - longint'($urandom_range(0, 2 * drop + 2));
          push_alt(AW'((fall < ALT_MIN) ? longint'(ALT_MIN) : fall));
          k++;
        end
      end
    end
  endtask

  // Release samples at or above the landing height, so the phase holds
  task automatic release_run(input int land, input int count);
    settle();
    write_reg(REG_LANDING_HEIGHT, land);
    repeat (count)
      push_alt(($urandom_range(0, 7) == 0) ? AW'(land) : alt_between(land, ALT_MAX));
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.altitude_cm = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pad under default thresholds
    foreach (PAD_SEQ[i]) push_alt(AW'(PAD_SEQ[i]));

    // Pad lingering; the result side holds off first, so the opening pause waits it out
    hold_asks <= hold_asks + 1;
    pad_run(ALT_MAX, 1, 250);
    pad_run(0, 255, 150);
    pad_run($urandom_range(1, ALT_MAX - 1), $urandom_range(2, 16), 150);
    pad_run($urandom_range(1, ALT_MAX - 1), $urandom_range(2, 16), 150);

    // Launch after the longest allowed run above a zero takeoff height
    settle();
    write_reg(REG_TAKEOFF_HEIGHT, 0);
    write_reg(REG_TAKEOFF_SAMPLES, 255);
    push_alt('0);
    repeat (255) push_alt(alt_between(1, ALT_MAX));

    // Ascent with an unreachable minimum apogee: counters run, no transition
    settle();
    write_reg(REG_MIN_APOGEE, ALT_MAX);
    climb_run(0, 1, 120);
    climb_run(0, 0, 40);
    climb_run(ALT_MAX, 255, 120);
    climb_run($urandom_range(1, 5000), $urandom_range(1, 8), 160);
    climb_run($urandom_range(0, ALT_MAX), $urandom_range(1, 255), 120);

    // Confirm apogee, then one step into release with deploy latched
    settle();
    write_reg(REG_DESCENT_DROP, 100);
    write_reg(REG_DESCENT_SAMPLES, 3);
    write_reg(REG_MIN_APOGEE, 0);
    foreach (APOGEE_SEQ[i]) push_alt(AW'(APOGEE_SEQ[i]));

    // Release lingering at the landing-height extremes and one random height
    release_run(0, 150);
    release_run(ALT_MAX, 10);
    release_run($urandom_range(1, ALT_MAX - 1), 60);

    // Land on the boundary, then latch the landed flag
    settle();
    write_reg(REG_LANDING_HEIGHT, 1000);
    push_alt(AW'(1000));
    push_alt(AW'(999));
    push_alt(AW'(ALT_MIN));

    // Landed: back-pressure fill, full pause, register churn, random samples
    hold_asks <= hold_asks + 1;
    repeat (40) push_alt(AW'($urandom));
    settle();
    write_reg(REG_TAKEOFF_HEIGHT, $urandom_range(0, ALT_MAX));
    write_reg(REG_TAKEOFF_SAMPLES, $urandom_range(0, 255));
    write_reg(REG_DESCENT_DROP, $urandom_range(0, ALT_MAX));
    write_reg(REG_DESCENT_SAMPLES, $urandom_range(0, 255));
    write_reg(REG_MIN_APOGEE, $urandom_range(0, ALT_MAX));
    write_reg(REG_LANDING_HEIGHT, ALT_MAX);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    repeat (210) push_alt(AW'($urandom));

    settle();
    repeat (4) @(posedge clk);
    if (pending_results != 0)
      $display("%0d predicted results never arrived", pending_results);
    $display("Covered %0d altitude samples from pad through landed, %0d register writes,",
             samples_sent, reg_writes);
    $display("with bursty input, rotating output stalls and long output hold-offs.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
